// ----- sv/stepper_back_and_forth_sequencer_core_defines.svh -----
// ----------------------------------------------------------------------------
// Stepper sequencer assertion macros
// Shared macros for the concurrent checks of the sequencer core. All checks
// run on aclk and are disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef STEPPER_BACK_AND_FORTH_SEQUENCER_CORE_DEFINES_SVH
`define STEPPER_BACK_AND_FORTH_SEQUENCER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SBF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SBF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/sbf_pkg.sv -----
// ----------------------------------------------------------------------------
// Stepper sequencer package
// Field widths, request, state and pulse codes, register indexes and the
// reset values of the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

package sbf_pkg;

    // Field widths.
    localparam int REQ_W   = 2;
    localparam int MODE_W  = 2;
    localparam int STATE_W = 2;
    localparam int PULSE_W = 2;
    localparam int CNT_W   = 16;
    localparam int IDX_W   = 3;

    typedef logic [REQ_W-1:0]   req_t;
    typedef logic [MODE_W-1:0]  mode_t;
    typedef logic [STATE_W-1:0] run_state_t;
    typedef logic [PULSE_W-1:0] pulse_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [IDX_W-1:0]   cfg_idx_t;

    // Request codes.
    localparam req_t REQ_TICK   = 2'd0;
    localparam req_t REQ_START  = 2'd1;
    localparam req_t REQ_STOP   = 2'd2;
    localparam req_t REQ_SETDIR = 2'd3;

    // Run states.
    localparam run_state_t ST_IDLE    = 2'd0;
    localparam run_state_t ST_RUNNING = 2'd1;
    localparam run_state_t ST_STOPPED = 2'd2;

    // Step pulse codes.
    localparam pulse_t PULSE_NONE = 2'd0;
    localparam pulse_t PULSE_FWD  = 2'd1;
    localparam pulse_t PULSE_BWD  = 2'd2;

    // Profile codes.
    localparam mode_t PROF_ECO    = 2'd0;
    localparam mode_t PROF_NORMAL = 2'd1;

    // Configuration register indexes.
    localparam cfg_idx_t CFG_MODE_SELECT  = 3'd0;
    localparam cfg_idx_t CFG_ECO_STEPS    = 3'd1;
    localparam cfg_idx_t CFG_NORMAL_STEPS = 3'd2;
    localparam cfg_idx_t CFG_FAST_STEPS   = 3'd3;
    localparam cfg_idx_t CFG_ECO_DELAY    = 3'd4;
    localparam cfg_idx_t CFG_NORMAL_DELAY = 3'd5;
    localparam cfg_idx_t CFG_FAST_DELAY   = 3'd6;
    localparam cfg_idx_t CFG_PAUSE_TICKS  = 3'd7;

    // Reset values.
    localparam mode_t RST_MODE_SELECT  = PROF_NORMAL;
    localparam cnt_t  RST_ECO_STEPS    = 16'd1024;
    localparam cnt_t  RST_NORMAL_STEPS = 16'd2048;
    localparam cnt_t  RST_FAST_STEPS   = 16'd4096;
    localparam cnt_t  RST_DELAY        = 16'd1;
    localparam cnt_t  RST_PAUSE_TICKS  = 16'd1000;
    localparam cnt_t  CNT_MAX          = 16'hFFFF;

    // Saturating increment of a 16-bit counter.
    function automatic cnt_t sat_inc(input cnt_t v);
        return (v == CNT_MAX) ? v : v + cnt_t'(1);
    endfunction

endpackage

`default_nettype wire

// ----- sv/stepper_back_and_forth_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// Back-and-forth stepper sequencer core
// Runs sweeps of step pulses on 1 ms ticks, pauses with the coils released,
// reverses direction and sweeps again until stopped.
// ----------------------------------------------------------------------------
// Each request transfer (tick, start, stop or direction set) yields exactly
// one result transfer. The sequencer state is updated in the cycle the
// request is accepted, and the result appears in the output register on the
// next cycle. A new request can be accepted every cycle as long as the
// output register is empty or being drained in the same cycle, so the
// sustained rate is one item per clock, paced only by m_ready. Configuration
// writes are accepted in any cycle. The profile registers and the mode
// select take effect at the next start; the pause length applies from the
// next tick, also to a pause already in progress.
`default_nettype none

`include "stepper_back_and_forth_sequencer_core_defines.svh"

module stepper_back_and_forth_sequencer_core (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Request channel.
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire sbf_pkg::req_t         s_req_type,
    input  wire logic                  s_new_direction,
    // Result channel.
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output sbf_pkg::pulse_t            m_step_pulse,
    output logic                       m_release_coils,
    output sbf_pkg::run_state_t        m_run_state,
    output logic                       m_direction_now,
    output logic                       m_pausing,
    // Configuration write channel.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire sbf_pkg::cfg_idx_t     cfg_index,
    input  wire sbf_pkg::cnt_t         cfg_data
);

    import sbf_pkg::*;

    // Configuration registers.
    mode_t mode_select_reg;
    cnt_t  eco_steps_reg, normal_steps_reg, fast_steps_reg;
    cnt_t  eco_delay_reg, normal_delay_reg, fast_delay_reg;
    cnt_t  pause_ticks_reg;

    // Sequencer state.
    run_state_t mode_state_reg, mode_state_next;
    logic       direction_reg, direction_next;
    logic       pause_flag_reg, pause_flag_next;
    cnt_t       steps_done_reg, steps_done_next;
    cnt_t       target_steps_reg, target_steps_next;
    cnt_t       step_delay_reg, step_delay_next;
    cnt_t       step_elapsed_reg, step_elapsed_next;
    cnt_t       pause_elapsed_reg, pause_elapsed_next;

    // Result register.
    logic       out_valid_reg;
    pulse_t     out_pulse_reg, out_pulse_next;
    logic       out_release_reg, out_release_next;

    logic       in_xfer;
    cnt_t       step_elapsed_inc;
    cnt_t       pause_elapsed_inc;
    cnt_t       steps_done_inc;
    cnt_t       prof_steps;
    cnt_t       prof_delay;

    // Handshakes: the output register frees up when it is empty or drained.
    assign s_ready   = !out_valid_reg || m_ready;
    assign in_xfer   = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // Configuration write decode.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_select_reg  <= RST_MODE_SELECT;
            eco_steps_reg    <= RST_ECO_STEPS;
            normal_steps_reg <= RST_NORMAL_STEPS;
            fast_steps_reg   <= RST_FAST_STEPS;
            eco_delay_reg    <= RST_DELAY;
            normal_delay_reg <= RST_DELAY;
            fast_delay_reg   <= RST_DELAY;
            pause_ticks_reg  <= RST_PAUSE_TICKS;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_MODE_SELECT:  mode_select_reg  <= cfg_data[MODE_W-1:0];
                CFG_ECO_STEPS:    eco_steps_reg    <= cfg_data;
                CFG_NORMAL_STEPS: normal_steps_reg <= cfg_data;
                CFG_FAST_STEPS:   fast_steps_reg   <= cfg_data;
                CFG_ECO_DELAY:    eco_delay_reg    <= cfg_data;
                CFG_NORMAL_DELAY: normal_delay_reg <= cfg_data;
                CFG_FAST_DELAY:   fast_delay_reg   <= cfg_data;
                CFG_PAUSE_TICKS:  pause_ticks_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Profile chosen at start; codes above normal use the fast profile.
    always_comb begin
        case (mode_select_reg)
            PROF_ECO: begin
                prof_steps = eco_steps_reg;
                prof_delay = eco_delay_reg;
            end
            PROF_NORMAL: begin
                prof_steps = normal_steps_reg;
                prof_delay = normal_delay_reg;
            end
            default: begin
                prof_steps = fast_steps_reg;
                prof_delay = fast_delay_reg;
            end
        endcase
    end

    assign step_elapsed_inc  = sat_inc(step_elapsed_reg);
    assign pause_elapsed_inc = sat_inc(pause_elapsed_reg);
    assign steps_done_inc    = sat_inc(steps_done_reg);

    // Next state and result for the request being accepted.
    always_comb begin
        mode_state_next    = mode_state_reg;
        direction_next     = direction_reg;
        pause_flag_next    = pause_flag_reg;
        steps_done_next    = steps_done_reg;
        target_steps_next  = target_steps_reg;
        step_delay_next    = step_delay_reg;
        step_elapsed_next  = step_elapsed_reg;
        pause_elapsed_next = pause_elapsed_reg;
        out_pulse_next     = PULSE_NONE;
        out_release_next   = 1'b0;

        case (s_req_type)
            REQ_START: begin
                // A pause in progress is kept across a start.
                target_steps_next = prof_steps;
                step_delay_next   = prof_delay;
                step_elapsed_next = '0;
                steps_done_next   = '0;
                mode_state_next   = ST_RUNNING;
            end
            REQ_STOP: begin
                out_release_next = 1'b1;
                pause_flag_next  = 1'b0;
                mode_state_next  = ST_STOPPED;
            end
            REQ_SETDIR: begin
                direction_next = s_new_direction;
            end
            default: begin
                if (mode_state_reg == ST_RUNNING) begin
                    if (pause_flag_reg) begin
                        // Pause countdown; on expiry reverse and restart the sweep.
                        pause_elapsed_next = pause_elapsed_inc;
                        if (pause_elapsed_inc >= pause_ticks_reg) begin
                            pause_flag_next   = 1'b0;
                            steps_done_next   = '0;
                            step_elapsed_next = '0;
                            direction_next    = !direction_reg;
                        end
                    end else begin
                        // Step timing; the last step of a sweep starts the pause.
                        step_elapsed_next = step_elapsed_inc;
                        if (step_elapsed_inc >= step_delay_reg) begin
                            step_elapsed_next = '0;
                            out_pulse_next    = direction_reg ? PULSE_BWD : PULSE_FWD;
                            steps_done_next   = steps_done_inc;
                            if (steps_done_inc >= target_steps_reg) begin
                                out_release_next   = 1'b1;
                                pause_flag_next    = 1'b1;
                                pause_elapsed_next = '0;
                            end
                        end
                    end
                end
            end
        endcase
    end

    // Sequencer state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_state_reg    <= ST_IDLE;
            direction_reg     <= 1'b0;
            pause_flag_reg    <= 1'b0;
            steps_done_reg    <= '0;
            target_steps_reg  <= '0;
            step_delay_reg    <= RST_DELAY;
            step_elapsed_reg  <= '0;
            pause_elapsed_reg <= '0;
        end else if (in_xfer) begin
            mode_state_reg    <= mode_state_next;
            direction_reg     <= direction_next;
            pause_flag_reg    <= pause_flag_next;
            steps_done_reg    <= steps_done_next;
            target_steps_reg  <= target_steps_next;
            step_delay_reg    <= step_delay_next;
            step_elapsed_reg  <= step_elapsed_next;
            pause_elapsed_reg <= pause_elapsed_next;
        end
    end

    // Output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_xfer) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload; the state fields come straight from the state registers.
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            out_pulse_reg   <= out_pulse_next;
            out_release_reg <= out_release_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_step_pulse    = out_pulse_reg;
    assign m_release_coils = out_release_reg;
    assign m_run_state     = mode_state_reg;
    assign m_direction_now = direction_reg;
    assign m_pausing       = pause_flag_reg;

    // A pause only exists inside a running sweep.
    `SBF_ASSERT_NOW(a_pause_only_running, pause_flag_reg, mode_state_reg == ST_RUNNING,
        "pause flag set outside the running state")

    // A step pulse goes out only while running and in the current direction.
    `SBF_ASSERT_NOW(a_pulse_matches_dir, m_valid && (m_step_pulse != PULSE_NONE),
        (m_run_state == ST_RUNNING) &&
        (m_step_pulse == (m_direction_now ? PULSE_BWD : PULSE_FWD)),
        "step pulse inconsistent with state or direction")

    // Releasing the coils without a final step only happens on a stop.
    `SBF_ASSERT_NOW(a_release_stop,
        m_valid && m_release_coils && (m_step_pulse == PULSE_NONE),
        m_run_state == ST_STOPPED, "coils released without a stop or sweep end")

    // An accepted stop leaves the block stopped with no pause.
    `SBF_ASSERT_NEXT(a_stop_effect, in_xfer && (s_req_type == REQ_STOP),
        (mode_state_reg == ST_STOPPED) && !pause_flag_reg && out_release_reg,
        "stop request did not take effect")

endmodule

`default_nettype wire
